// File: rtl/uu_pkg.sv
// uu_pkg: shared types, character constants and the 6-bit to ASCII mapping
// for the uuencode stream encoder. No dependencies.

package uu_pkg;

    // Most characters one input byte can produce:
    // length char, four group chars, newline, six footer chars.
    localparam int NUM_SLOTS = 12;
    localparam int SLOT_W    = 4;

    typedef logic [7:0] t_char;

    localparam t_char CHAR_BQ = 8'h60;  // backquote, stands for a zero value
    localparam t_char CHAR_NL = 8'h0a;
    localparam t_char CHAR_E  = 8'h65;
    localparam t_char CHAR_N  = 8'h6e;
    localparam t_char CHAR_D  = 8'h64;

    // Characters caused by one byte, in output order.
    typedef struct packed {
        logic [NUM_SLOTS-1:0][7:0] chars;
        logic [SLOT_W-1:0]         count;
        logic                      msg_end;  // burst closes the message
    } t_burst;

    function automatic t_char code_char(input logic [5:0] v);
        code_char = (v == 6'd0) ? CHAR_BQ : t_char'({2'b00, v} + 8'd32);
    endfunction

endpackage

// File: rtl/uuencode_stream_encoder_unit.sv
// uuencode_stream_encoder_unit: top level of the uuencode body/footer encoder.
// Depends on uu_pkg, uu_encode_core and uu_char_buffer.
//
//   channel | direction | handshake                    | payload
//   --------+-----------+------------------------------+------------------------------
//   in      | sink      | i_in_valid / o_in_ready      | i_data_byte
//   out     | source    | o_out_valid / i_out_ready    | o_out_char, o_run_last,
//           |           |                              | o_message_done
//   cfg     | APB slave | psel, penable, pwrite, pready| paddr, pwdata, prdata
//
// A byte lands in an input register, is expanded combinationally into its burst
// of 0 to 12 characters in the buffer, and the burst plays out one transfer per
// cycle while the receiver is ready. A byte that makes no characters holds
// nothing up; else the output port's one-transfer-per-cycle limit sets the pace.
// The next byte is expanded in the cycle the previous burst's last char leaves.
// Reset is synchronous, active low, with no clearing pass.
// A stall on the output holds the burst; the input register still takes a byte.

module uuencode_stream_encoder_unit #(
    parameter int LINE_BYTES = 45
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte input
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    // character output
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_char,
    output logic        o_run_last,
    output logic        o_message_done,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic           r_in_valid;
    logic [7:0]     r_in_byte;
    logic           load;
    logic           can_load;
    logic           cfg_wr;
    logic [31:0]    msg_len;
    uu_pkg::t_burst burst;

    // Only message_length exists: register index sits in paddr[2].
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign prdata = (paddr[2] == 1'b0) ? msg_len : 32'd0;

    // Expand the held byte once the buffer is empty or about to drain.
    assign load       = r_in_valid && can_load;
    assign o_in_ready = !r_in_valid || load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (load) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_data_byte;
        end
    end

    uu_encode_core #(
        .LINE_BYTES (LINE_BYTES)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_wr  (cfg_wr),
        .i_cfg_len (pwdata),
        .i_load    (load),
        .i_byte    (r_in_byte),
        .o_msg_len (msg_len),
        .o_burst   (burst)
    );

    uu_char_buffer u_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (load),
        .i_burst    (burst),
        .o_can_load (can_load),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_char     (o_out_char),
        .o_last     (o_run_last),
        .o_done     (o_message_done)
    );

endmodule

// File: rtl/uu_encode_core.sv
// uu_encode_core: message/line/group state and the expansion of one byte
// into its burst of output characters. Depends on uu_pkg.

module uu_encode_core #(
    parameter int LINE_BYTES = 45
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_wr,
    input  logic [31:0]    i_cfg_len,
    input  logic           i_load,
    input  logic [7:0]     i_byte,
    output logic [31:0]    o_msg_len,
    output uu_pkg::t_burst o_burst
);

    localparam int POS_W = $clog2(LINE_BYTES);

    logic [31:0]      r_msg_len;
    logic [31:0]      r_remaining;
    logic [POS_W-1:0] r_pos;
    logic [1:0]       r_phase;   // position within the 3-byte group
    logic [7:0]       r_held_first;
    logic [7:0]       r_held_second;

    logic       last;
    logic       eol;
    logic [1:0] phase_nxt;
    logic [7:0] h1, h2, h3;
    logic [5:0] len_val;

    assign last      = (r_remaining == 32'd1);
    assign eol       = last || (r_pos == POS_W'(LINE_BYTES - 1));
    assign phase_nxt = (r_phase == 2'd2) ? 2'd0 : r_phase + 2'd1;

    // Group bytes; bytes not yet present read as zero for padding.
    assign h1 = (r_phase == 2'd0) ? i_byte : r_held_first;
    assign h2 = (r_phase == 2'd0) ? 8'd0 : ((r_phase == 2'd1) ? i_byte : r_held_second);
    assign h3 = (r_phase == 2'd2) ? i_byte : 8'd0;

    assign len_val = (r_remaining != 32'd0 && r_remaining < 32'(LINE_BYTES))
                   ? r_remaining[5:0] : 6'(LINE_BYTES);

    always_comb begin
        logic [uu_pkg::SLOT_W-1:0] n;
        n = '0;
        o_burst.chars = '0;
        if (r_pos == '0) begin
            o_burst.chars[n] = uu_pkg::code_char(len_val);
            n = n + 1'b1;
        end
        // Completed group, or the padded partial group at a line end.
        if (r_phase == 2'd2 || eol) begin
            o_burst.chars[n]     = uu_pkg::code_char(h1[7:2]);
            o_burst.chars[n + 1] = uu_pkg::code_char({h1[1:0], h2[7:4]});
            o_burst.chars[n + 2] = uu_pkg::code_char({h2[3:0], h3[7:6]});
            o_burst.chars[n + 3] = uu_pkg::code_char(h3[5:0]);
            n = n + 4'd4;
        end
        if (eol) begin
            o_burst.chars[n] = uu_pkg::CHAR_NL;
            n = n + 1'b1;
        end
        if (last) begin
            o_burst.chars[n]     = uu_pkg::CHAR_BQ;
            o_burst.chars[n + 1] = uu_pkg::CHAR_NL;
            o_burst.chars[n + 2] = uu_pkg::CHAR_E;
            o_burst.chars[n + 3] = uu_pkg::CHAR_N;
            o_burst.chars[n + 4] = uu_pkg::CHAR_D;
            o_burst.chars[n + 5] = uu_pkg::CHAR_NL;
            n = n + 4'd6;
        end
        o_burst.count   = n;
        o_burst.msg_end = last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_msg_len     <= 32'd1;
            r_remaining   <= 32'd1;
            r_pos         <= '0;
            r_phase       <= 2'd0;
            r_held_first  <= 8'd0;
            r_held_second <= 8'd0;
        end else if (i_cfg_wr) begin
            r_msg_len     <= i_cfg_len;
            r_remaining   <= i_cfg_len;
            r_pos         <= '0;
            r_phase       <= 2'd0;
            r_held_first  <= 8'd0;
            r_held_second <= 8'd0;
        end else if (i_load) begin
            r_remaining <= last ? r_msg_len : r_remaining - 32'd1;
            r_pos       <= eol ? '0 : r_pos + 1'b1;
            r_phase     <= eol ? 2'd0 : phase_nxt;
            if (last) begin
                r_held_first  <= 8'd0;
                r_held_second <= 8'd0;
            end else if (r_phase == 2'd0) begin
                r_held_first <= i_byte;
            end else if (r_phase == 2'd1) begin
                r_held_second <= i_byte;
            end
        end
    end

    assign o_msg_len = r_msg_len;

endmodule

// File: rtl/uu_char_buffer.sv
// uu_char_buffer: holds one burst of characters and plays it out one
// transfer per cycle while the receiver is ready. Depends on uu_pkg.

module uu_char_buffer (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  uu_pkg::t_burst i_burst,
    output logic           o_can_load,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [7:0]     o_char,
    output logic           o_last,
    output logic           o_done
);

    logic [uu_pkg::NUM_SLOTS-1:0][7:0] r_chars;
    logic [uu_pkg::SLOT_W-1:0]         r_count;
    logic [uu_pkg::SLOT_W-1:0]         r_rd;
    logic                              r_msg_end;

    assign o_valid    = (r_rd != r_count);
    assign o_last     = o_valid && (r_rd == r_count - 1'b1);
    assign o_can_load = !o_valid || (o_last && i_ready);
    assign o_char     = r_chars[r_rd];
    assign o_done     = o_last && r_msg_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_rd      <= '0;
            r_msg_end <= 1'b0;
        end else if (i_load) begin
            r_count   <= i_burst.count;
            r_rd      <= '0;
            r_msg_end <= i_burst.msg_end;
        end else if (o_valid && i_ready) begin
            r_rd <= r_rd + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_chars <= i_burst.chars;
        end
    end

    a_rd_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd <= r_count && r_count <= uu_pkg::SLOT_W'(uu_pkg::NUM_SLOTS))
        else $error("read pointer beyond burst");

    a_done_on_nl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_last && o_char == uu_pkg::CHAR_NL))
        else $error("message end not on final newline");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_load && i_burst.count != '0) |=> (o_valid && r_rd == '0))
        else $error("loaded burst not presented");

endmodule

// File: tb/sv/uu_char_sb_pkg.sv
// uu_char_sb_pkg: predicted uuencode character stream and its scoreboard.
// Depends on uu_pkg for the character type and the fixed ASCII codes.

package uu_char_sb_pkg;

    typedef struct {
        uu_pkg::t_char ch;
        bit            last;
        bit            done;
    } t_enc_char;

    class uu_text_scoreboard;

        localparam int LINE_BYTES = 45;
        localparam int SHOW_MAX   = 10;

        bit [31:0]     msg_len;
        bit [31:0]     left;
        int            pos;
        uu_pkg::t_char hold_a;
        uu_pkg::t_char hold_b;
        int            bad_count;
        t_enc_char     due_chars[$];

        function new();
            msg_len   = 32'd1;
            left      = 32'd1;
            pos       = 0;
            hold_a    = '0;
            hold_b    = '0;
            bad_count = 0;
        endfunction

        function void flag(string msg);
            if (bad_count < SHOW_MAX)
                $display("%s", msg);
            bad_count++;
        endfunction

        function int pending();
            return due_chars.size();
        endfunction

        // A length write restarts the message.
        function void set_length(bit [31:0] v);
            msg_len = v;
            left    = v;
            pos     = 0;
            hold_a  = '0;
            hold_b  = '0;
        endfunction

        function uu_pkg::t_char to_printable(bit [5:0] v);
            return (v == 6'd0) ? uu_pkg::CHAR_BQ : uu_pkg::t_char'({2'b00, v} + 8'd32);
        endfunction

        function void push(uu_pkg::t_char c, bit d);
            t_enc_char e;
            e.ch   = c;
            e.last = 1'b0;
            e.done = d;
            due_chars.push_back(e);
        endfunction

        // Missing bytes of a padded group are passed as zero.
        function void push_group(uu_pkg::t_char a, uu_pkg::t_char b, uu_pkg::t_char c);
            push(to_printable(a[7:2]), 1'b0);
            push(to_printable({a[1:0], b[7:4]}), 1'b0);
            push(to_printable({b[3:0], c[7:6]}), 1'b0);
            push(to_printable(c[5:0]), 1'b0);
        endfunction

        function void take_byte(uu_pkg::t_char b);
            bit [31:0] cnt;
            int        mark;
            bit        ends;
            mark = due_chars.size();
            if (pos >= LINE_BYTES)
                pos = 0;
            if (pos == 0) begin
                cnt = (left != 0 && left < LINE_BYTES) ? left : LINE_BYTES;
                push(to_printable(cnt[5:0]), 1'b0);
            end
            case (pos % 3)
                0: hold_a = b;
                1: hold_b = b;
                default: push_group(hold_a, hold_b, b);
            endcase
            left = left - 1;
            pos++;
            ends = (left == 0);
            if (ends || pos >= LINE_BYTES) begin
                case (pos % 3)
                    1: push_group(hold_a, 8'h00, 8'h00);
                    2: push_group(hold_a, hold_b, 8'h00);
                    default: ;
                endcase
                push(uu_pkg::CHAR_NL, 1'b0);
                pos = 0;
            end
            if (ends) begin
                push(uu_pkg::CHAR_BQ, 1'b0);
                push(uu_pkg::CHAR_NL, 1'b0);
                push(uu_pkg::CHAR_E, 1'b0);
                push(uu_pkg::CHAR_N, 1'b0);
                push(uu_pkg::CHAR_D, 1'b0);
                push(uu_pkg::CHAR_NL, 1'b1);
                left   = msg_len;
                hold_a = '0;
                hold_b = '0;
            end
            if (due_chars.size() > mark)
                due_chars[due_chars.size() - 1].last = 1'b1;
        endfunction

        function void match_char(uu_pkg::t_char ch, bit last, bit done);
            t_enc_char e;
            if (due_chars.size() == 0) begin
                flag($sformatf("unexpected char %02h last %0b done %0b", ch, last, done));
                return;
            end
            e = due_chars.pop_front();
            if (e.ch !== ch || e.last !== last || e.done !== done)
                flag($sformatf("char mismatch: want %02h/%0b/%0b got %02h/%0b/%0b",
                               e.ch, e.last, e.done, ch, last, done));
        endfunction

    endclass

endpackage

// File: tb/sv/tb_top.sv
// tb_top: stream test of uuencode_stream_encoder_unit with random handshake gaps.
// Depends on uu_pkg and uu_char_sb_pkg; drives the APB port and both streams.

module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] ADDR_MSG_LEN = 3'd0;
    localparam int         DRAIN_CYCLES = 16;    // covers a byte that makes no chars
    localparam int         RAND_ITEMS   = 150;
    localparam int         HOLD_CYCLES  = 300;   // long receiver hold-off

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        i_in_valid    = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_data_byte   = 8'h00;
    logic        o_out_valid;
    logic        i_out_ready   = 1'b0;
    logic [7:0]  o_out_char;
    logic        o_run_last;
    logic        o_message_done;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = 3'd0;
    logic [31:0] pwdata        = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    uu_char_sb_pkg::uu_text_scoreboard sb = new();

    int tx_count = 0;
    int rx_count = 0;
    bit hold_rx  = 1'b0;   // main asks the receiver for one long stall

    uuencode_stream_encoder_unit u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_data_byte    (i_data_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_char     (o_out_char),
        .o_run_last     (o_run_last),
        .o_message_done (o_message_done),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Gap before an item; every third run of 16 items goes without gaps.
    function automatic int pick_gap(int n);
        return (((n >> 4) % 3) == 1) ? 0 : $urandom_range(0, 17);
    endfunction

    // One byte transfer. Valid is only lowered when a gap is drawn, so a
    // back-to-back item never sees valid dropped and raised in one step.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap(tx_count);
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        sb.take_byte(i_data_byte);
        tx_count++;
    endtask

    task automatic tx_release();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    // Wait out every expected char, then a further wait for a silent byte.
    task automatic drain();
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // APB write of the length register, then a read-back of it.
    task automatic write_length(input logic [31:0] v);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_MSG_LEN;
        pwdata  <= v;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_length(v);
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== v)
            sb.flag($sformatf("length read-back: want %08h got %08h", v, prdata));
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic new_length(input logic [31:0] v);
        tx_release();
        drain();
        write_length(v);
    endtask

    // Receiver: random ready gaps, one long hold-off on request, and a
    // check of every char transfer against the prediction.
    initial begin : rx_side
        int gap;
        bit held;
        held = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_rx && !held) begin
                held = 1'b1;
                @(negedge i_clk);
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            gap = pick_gap(rx_count);
            if (gap > 0) begin
                @(negedge i_clk);
                i_out_ready <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_out_valid && i_out_ready));
            sb.match_char(o_out_char, o_run_last, o_message_done);
            rx_count++;
        end
    end

    initial begin : run_limit
        #5_000_000;
        $display("tb_top: errors");
        $finish;
    end

    initial begin : main
        int          sent;
        int          phase;
        int          n;
        logic [31:0] len;

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset length of one: every byte is a whole message with footer.
        send_byte(8'h00);
        send_byte(8'hFF);

        // Zero length counts as 2^32 bytes; the write after drops it.
        new_length(32'd0);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h80);
        send_byte(8'h01);
        send_byte(8'hFE);

        // Largest length, abandoned mid-line.
        new_length(32'hFFFF_FFFF);
        send_byte(8'h3F);
        send_byte(8'hC0);
        send_byte(8'hFC);

        // Two-byte message: group padded after its second byte.
        new_length(32'd2);
        send_byte(8'h55);
        send_byte(8'hAA);

        // Four bytes: one full group, then one padded after a single byte.
        new_length(32'd4);
        send_byte(8'h12);
        send_byte(8'h34);
        send_byte(8'h56);
        send_byte(8'h78);

        // Length 3 twice in a row: the counter reloads after the footer.
        new_length(32'd3);
        repeat (6) send_byte(8'($urandom_range(0, 255)));

        // Random phases, the first one with a length past a full line.
        sent    = 0;
        phase   = 0;
        while (sent < RAND_ITEMS) begin
            if (phase == 0)
                len = 32'd47;
            else begin
                case ($urandom_range(0, 11))
                    0:       len = 32'd45;
                    1:       len = 32'd46;
                    2:       len = 32'd44;
                    3:       len = 32'($urandom_range(88, 92));
                    4:       len = 32'hFFFF_FFFF;
                    default: len = 32'($urandom_range(1, 12));
                endcase
            end
            // Mostly whole messages, some cut short by the next write.
            if (len > 100 || $urandom_range(0, 4) == 0)
                n = $urandom_range(1, 40);
            else if (len > 40)
                n = len;
            else
                n = len * $urandom_range(1, 3);
            if (n > RAND_ITEMS - sent)
                n = RAND_ITEMS - sent;
            new_length(len);
            // Receiver stalls while the sender keeps offering bytes.
            if (phase == 0)
                hold_rx = 1'b1;
            repeat (n) send_byte(8'($urandom_range(0, 255)));
            sent += n;
            phase++;
        end

        tx_release();
        drain();
        if (sb.bad_count == 0 && sb.pending() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
